FILE: hw/rtl/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants for the tty input line discipline
// Character codes, option bit positions, register indexes, result kinds and
// the command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tld_pkg;

  // character codes
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SP      = 8'd32;
  localparam logic [7:0] CH_UP      = 8'd94;
  localparam logic [7:0] CH_DEL     = 8'o177;
  localparam logic [7:0] VIS_OFFSET = 8'o100;

  // option_flags bit positions
  localparam int OPT_CRMAP = 0;
  localparam int OPT_FLOW  = 1;
  localparam int OPT_ECHO  = 2;
  localparam int OPT_KILL  = 3;
  localparam int OPT_ERASE = 4;
  localparam int OPT_EOF   = 5;
  localparam int OPT_VIS   = 6;
  localparam int OPT_EBACK = 7;
  localparam int OPT_ECRLF = 8;

  // input modes
  localparam logic [1:0] MODE_RAW    = 2'd0;
  localparam logic [1:0] MODE_CBREAK = 2'd1;

  // action codes
  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OPTIONS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_CHAR  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_CHAR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KILL_CHAR   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ERASE_CHAR  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_EOF_CHAR    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_CHAR   = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_NO_ECHO = 2'd3;

  // result list per transaction
  localparam int MAX_RESULTS = 6;
  localparam int SEL_W       = 3;

  // controller -> datapath
  typedef struct packed {
    logic             load;   // capture input transaction
    logic             fetch;  // issue line store read
    logic             exec;   // apply the step, build result list
    logic [SEL_W-1:0] sel;    // result slot on the output
  } tld_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic final_sel;  // selected slot is the last result
  } tld_stat_t;

  // echo of one character: up to two bytes
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] n;
  } tld_echo_t;

  function automatic logic tld_is_ctrl(input logic [7:0] c);
    return (c < CH_SP) || (c == CH_DEL);
  endfunction

  function automatic tld_echo_t tld_echo_char(input logic [7:0] c, input logic ecrlf,
                                              input logic vis);
    tld_echo_t e;
    if ((c == CH_LF || c == CH_CR) && ecrlf) begin
      e = '{b0: CH_CR, b1: CH_LF, n: 2'd2};
    end else if (tld_is_ctrl(c) && vis) begin
      e = '{b0: CH_UP, b1: 8'(c + VIS_OFFSET), n: 2'd2};
    end else begin
      e = '{b0: c, b1: 8'd0, n: 2'd1};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tld_ctrl.sv
// ----------------------------------------------------------------------------
// tld_ctrl: sequencing controller
// Takes one transaction at a time: capture, store read, execute, then hands
// out the result list one slot per output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tld_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tld_pkg::tld_cmd_t       cmd,
  input  wire tld_pkg::tld_stat_t stat
);

  typedef enum logic [1:0] {
    IDLE,
    FETCH,
    EXEC,
    EMIT
  } state_t;

  state_t                    state;
  logic [tld_pkg::SEL_W-1:0] sel;

  // commands decoded from state
  assign in_stall  = (state != IDLE);
  assign cmd.load  = (state == IDLE) && in_valid;
  assign cmd.fetch = (state == FETCH);
  assign cmd.exec  = (state == EXEC);
  assign cmd.sel   = sel;

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      sel       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) state <= FETCH;
        end
        FETCH: begin
          state <= EXEC;
        end
        EXEC: begin
          state     <= EMIT;
          sel       <= '0;
          out_valid <= 1'b1;
        end
        EMIT: begin
          if (!out_stall) begin
            if (stat.final_sel) begin
              state     <= IDLE;
              out_valid <= 1'b0;
              sel       <= '0;
            end else begin
              sel <= sel + 1'b1;
            end
          end
        end
        default: begin
          state     <= IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tld_datapath.sv
// ----------------------------------------------------------------------------
// tld_datapath: line store, indexes, counters and result list
// Holds the configuration registers and the line store memory, applies one
// receive or read step on command and keeps the results for output.
// ----------------------------------------------------------------------------
`default_nettype none

module tld_datapath #(
  parameter int BUF_DEPTH = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tld_pkg::tld_cmd_t                cmd,
  output tld_pkg::tld_stat_t                    stat,
  input  wire logic                             cfg_we,
  input  wire logic [tld_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tld_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             action,
  input  wire logic [7:0]                       rx_byte,
  output logic [1:0]                            result_kind,
  output logic [7:0]                            out_byte,
  output logic                                  last,
  output logic                                  output_held,
  output logic [7:0]                            committed_count
);

  localparam int IW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUF_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(BUF_DEPTH);
  localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(BUF_DEPTH);
  localparam logic [CW:0]   DEPTH_M1 = (CW + 1)'(BUF_DEPTH - 1);
  localparam int NR = tld_pkg::MAX_RESULTS;

  // configuration registers
  logic [1:0] input_mode;
  logic [8:0] option_flags;
  logic [7:0] start_char, stop_char, kill_char, erase_char, eof_char, full_char;

  // line discipline state
  logic [IW-1:0] read_index, write_index;
  logic [CW-1:0] readable_count, line_length;
  logic          hold_flag;

  // captured transaction
  logic       act;
  logic [7:0] c_in;

  // line store
  logic [7:0]    line_store [BUF_DEPTH];
  logic [7:0]    mem_rdata;
  logic [IW-1:0] mem_raddr;
  logic          mem_we;
  logic [7:0]    mem_wdata;

  // result list
  logic [7:0]               res_bytes [NR];
  logic [1:0]               res_kind;
  logic [tld_pkg::SEL_W-1:0] res_count;

  // next values
  logic [IW-1:0]             read_index_next, write_index_next;
  logic [CW-1:0]             readable_count_next, line_length_next;
  logic                      hold_flag_next;
  logic [7:0]                res_bytes_next [NR];
  logic [1:0]                res_kind_next;
  logic [tld_pkg::SEL_W-1:0] res_count_next;

  // helper values
  logic [IW-1:0]   wi_inc, wi_dec, ri_inc, kill_wi;
  logic [CW-1:0]   wi_ext;
  logic [CW:0]     eol_sum, pend_sum;
  logic [7:0]      c;
  logic            echo_on, vis, eback;
  tld_pkg::tld_echo_t ec;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode   <= 2'd2;
      option_flags <= 9'd511;
      start_char   <= 8'd17;
      stop_char    <= 8'd19;
      kill_char    <= 8'd21;
      erase_char   <= 8'd8;
      eof_char     <= 8'd4;
      full_char    <= 8'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        tld_pkg::REG_INPUT_MODE: input_mode   <= cfg_data[1:0];
        tld_pkg::REG_OPTIONS:    option_flags <= cfg_data;
        tld_pkg::REG_START_CHAR: start_char   <= cfg_data[7:0];
        tld_pkg::REG_STOP_CHAR:  stop_char    <= cfg_data[7:0];
        tld_pkg::REG_KILL_CHAR:  kill_char    <= cfg_data[7:0];
        tld_pkg::REG_ERASE_CHAR: erase_char   <= cfg_data[7:0];
        tld_pkg::REG_EOF_CHAR:   eof_char     <= cfg_data[7:0];
        tld_pkg::REG_FULL_CHAR:  full_char    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // capture input transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action;
      c_in <= rx_byte;
    end
  end

  // index arithmetic with wrap
  assign wi_inc  = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
  assign wi_dec  = (write_index == '0) ? LAST_IDX : write_index - 1'b1;
  assign ri_inc  = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
  assign wi_ext  = CW'(write_index);
  assign kill_wi = (wi_ext >= line_length) ? IW'(wi_ext - line_length)
                                           : IW'(CW'(wi_ext + DEPTH_C - line_length));
  assign eol_sum  = {1'b0, readable_count} + {1'b0, line_length} + 1'b1;
  assign pend_sum = {1'b0, readable_count} + {1'b0, line_length};

  // line store: read in fetch, write in exec
  assign mem_raddr = (act == tld_pkg::ACT_READ) ? read_index : wi_dec;

  always_ff @(posedge clk) begin
    if (mem_we) line_store[write_index] <= mem_wdata;
    if (cmd.fetch) mem_rdata <= line_store[mem_raddr];
  end

  // step logic
  assign c       = (c_in == tld_pkg::CH_CR && option_flags[tld_pkg::OPT_CRMAP]) ?
                   tld_pkg::CH_LF : c_in;
  assign echo_on = option_flags[tld_pkg::OPT_ECHO];
  assign vis     = option_flags[tld_pkg::OPT_VIS];
  assign eback   = option_flags[tld_pkg::OPT_EBACK];
  assign ec      = tld_pkg::tld_echo_char(c, option_flags[tld_pkg::OPT_ECRLF], vis);

  always_comb begin
    read_index_next     = read_index;
    write_index_next    = write_index;
    readable_count_next = readable_count;
    line_length_next    = line_length;
    hold_flag_next      = hold_flag;
    res_kind_next       = tld_pkg::KIND_ECHO;
    res_count_next      = '0;
    for (int i = 0; i < NR; i++) res_bytes_next[i] = 8'd0;
    mem_we    = 1'b0;
    mem_wdata = c;

    if (act == tld_pkg::ACT_READ) begin
      // reader takes one committed byte
      res_count_next = tld_pkg::SEL_W'(1);
      if (readable_count != '0) begin
        res_kind_next       = tld_pkg::KIND_READ;
        res_bytes_next[0]   = mem_rdata;
        read_index_next     = ri_inc;
        readable_count_next = readable_count - 1'b1;
      end else begin
        res_kind_next = tld_pkg::KIND_EMPTY;
      end
    end else if (input_mode == tld_pkg::MODE_RAW) begin
      // raw: store when room
      if (readable_count < DEPTH_C) begin
        mem_we              = 1'b1;
        mem_wdata           = c_in;
        write_index_next    = wi_inc;
        readable_count_next = readable_count + 1'b1;
      end
    end else if (option_flags[tld_pkg::OPT_FLOW] && c == start_char) begin
      hold_flag_next = 1'b0;
    end else if (option_flags[tld_pkg::OPT_FLOW] && c == stop_char) begin
      hold_flag_next = 1'b1;
    end else begin
      hold_flag_next = 1'b0;
      if (input_mode == tld_pkg::MODE_CBREAK) begin
        // cbreak: store and echo at once
        if (readable_count >= DEPTH_C) begin
          res_bytes_next[0] = full_char;
          res_count_next    = tld_pkg::SEL_W'(1);
        end else begin
          mem_we              = 1'b1;
          write_index_next    = wi_inc;
          readable_count_next = readable_count + 1'b1;
          if (echo_on) begin
            res_bytes_next[0] = ec.b0;
            res_bytes_next[1] = ec.b1;
            res_count_next    = tld_pkg::SEL_W'(ec.n);
          end
        end
      end else if (c == kill_char && option_flags[tld_pkg::OPT_KILL]) begin
        // line kill
        write_index_next  = kill_wi;
        line_length_next  = '0;
        res_bytes_next[0] = tld_pkg::CH_CR;
        res_bytes_next[1] = tld_pkg::CH_LF;
        res_count_next    = tld_pkg::SEL_W'(2);
      end else if (c == erase_char && option_flags[tld_pkg::OPT_ERASE]) begin
        // erase last pending byte; mem_rdata holds it
        if (line_length != '0) begin
          line_length_next = line_length - 1'b1;
          write_index_next = wi_dec;
          if (echo_on) begin
            for (int i = 0; i < NR; i++) begin
              res_bytes_next[i] = (eback && (i % 3 == 1)) ? tld_pkg::CH_SP : tld_pkg::CH_BS;
            end
            case ({eback, tld_pkg::tld_is_ctrl(mem_rdata) && vis})
              2'b00:   res_count_next = tld_pkg::SEL_W'(1);
              2'b01:   res_count_next = tld_pkg::SEL_W'(2);
              2'b10:   res_count_next = tld_pkg::SEL_W'(3);
              default: res_count_next = tld_pkg::SEL_W'(6);
            endcase
          end
        end
      end else if (c == tld_pkg::CH_LF || c == tld_pkg::CH_CR) begin
        // end of line commits the whole line
        if (echo_on) begin
          res_bytes_next[0] = ec.b0;
          res_bytes_next[1] = ec.b1;
          res_count_next    = tld_pkg::SEL_W'(ec.n);
        end
        mem_we              = 1'b1;
        write_index_next    = wi_inc;
        readable_count_next = (eol_sum > DEPTH_X) ? DEPTH_C : CW'(eol_sum);
        line_length_next    = '0;
      end else if (pend_sum >= DEPTH_M1) begin
        res_bytes_next[0] = full_char;
        res_count_next    = tld_pkg::SEL_W'(1);
      end else begin
        // EOF or ordinary byte
        if (echo_on) begin
          res_bytes_next[0] = ec.b0;
          res_bytes_next[1] = ec.b1;
          res_count_next    = tld_pkg::SEL_W'(ec.n);
        end
        if (c == eof_char && option_flags[tld_pkg::OPT_EOF]) begin
          if (line_length == '0) begin
            mem_we              = 1'b1;
            write_index_next    = wi_inc;
            readable_count_next = readable_count + 1'b1;
          end
        end else begin
          mem_we           = 1'b1;
          write_index_next = wi_inc;
          line_length_next = line_length + 1'b1;
        end
      end
    end

    // a receive without echo gives one silent result
    if (res_count_next == '0) begin
      res_kind_next  = tld_pkg::KIND_NO_ECHO;
      res_count_next = tld_pkg::SEL_W'(1);
    end

    if (!cmd.exec) mem_we = 1'b0;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index     <= '0;
      write_index    <= '0;
      readable_count <= '0;
      line_length    <= '0;
      hold_flag      <= 1'b0;
    end else if (cmd.exec) begin
      read_index     <= read_index_next;
      write_index    <= write_index_next;
      readable_count <= readable_count_next;
      line_length    <= line_length_next;
      hold_flag      <= hold_flag_next;
    end
  end

  // result list
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_bytes <= res_bytes_next;
      res_kind  <= res_kind_next;
      res_count <= res_count_next;
    end
  end

  // output fields
  logic [CW+7:0] rc_ext;
  assign rc_ext          = {8'd0, readable_count};
  assign stat.final_sel  = (cmd.sel == res_count - 1'b1);
  assign result_kind     = res_kind;
  assign out_byte        = (int'(cmd.sel) < NR) ? res_bytes[cmd.sel] : 8'd0;
  assign last            = stat.final_sel;
  assign output_held     = hold_flag;
  assign committed_count = rc_ext[7:0];

endmodule

`default_nettype wire

FILE: hw/rtl/tty_line_discipline_input_core.sv
// ----------------------------------------------------------------------------
// tty_line_discipline_input_core: terminal input line discipline
// Raw, cbreak and cooked line editing of received bytes, with echo output
// and a reader port on the committed bytes.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An accepted transaction is captured,
// then the line store is read, then the step is applied, then its results
// (1 to 6 results) are handed out one after another, each held while the
// output stalls; the line store's registered read port gives the read its
// own step. The input stalls until the last result of the current
// transaction is taken. The configuration port is always ready and must be
// written only while the block is idle; the block itself does not enforce
// this. The line store needs no clearing after reset.
`default_nettype none

module tty_line_discipline_input_core #(
  parameter int BUF_DEPTH = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            action,
  input  wire logic [7:0]                      rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           result_kind,
  output logic [7:0]                           out_byte,
  output logic                                 last,
  output logic                                 output_held,
  output logic [7:0]                           committed_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tld_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tld_pkg::tld_cmd_t  cmd;
  tld_pkg::tld_stat_t stat;

  assign cfg_ready = 1'b1;

  tld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  tld_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .rx_byte         (rx_byte),
    .result_kind     (result_kind),
    .out_byte        (out_byte),
    .last            (last),
    .output_held     (output_held),
    .committed_count (committed_count)
  );

endmodule

`default_nettype wire
